// ===== design/prm_pkg.sv =====
// Package for the polar range map query engine.
// Holds the shared constants, widths, command codes and the degree wrap helper.
package prm_pkg;

	localparam int PRM_MAP_DEGREES = 360;
	localparam int PRM_DEG_W       = 9;
	localparam int PRM_DIST_W      = 16;
	localparam int PRM_SUM_W       = 25;
	localparam int PRM_CNT_W       = 9;
	localparam int PRM_SCAN_HI     = 350;
	localparam int PRM_SCAN_LO     = 10;
	localparam int PRM_OBJ_FLOOR   = 80;
	localparam int PRM_NO_DEGREE   = 511;

	typedef enum logic [3:0] {
		CMD_POINT     = 4'd0,
		CMD_CLR_SCAN  = 4'd1,
		CMD_FARTHEST  = 4'd2,
		CMD_NEAREST   = 4'd3,
		CMD_SEC_MIN   = 4'd4,
		CMD_SEC_MAX   = 4'd5,
		CMD_SEC_AVG   = 4'd6,
		CMD_SEC_CLEAR = 4'd7,
		CMD_OBJECT    = 4'd8
	} prm_cmd_t;

	function automatic logic [PRM_DEG_W-1:0] prm_wrap(input logic signed [11:0] v);
		logic signed [11:0] r;
		if (v < -12'sd720) begin
			r = v + 12'sd1080;
		end else if (v < -12'sd360) begin
			r = v + 12'sd720;
		end else if (v < 12'sd0) begin
			r = v + 12'sd360;
		end else if (v >= 12'sd720) begin
			r = v - 12'sd720;
		end else if (v >= 12'sd360) begin
			r = v - 12'sd360;
		end else begin
			r = v;
		end
		return r[PRM_DEG_W-1:0];
	endfunction

endpackage

// ===== design/prm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module prm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/prm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the sector average.
// Depends on prm_pkg.
module prm_div import prm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PRM_SUM_W-1:0]  dividend,
	input  logic [PRM_CNT_W-1:0]  divisor,
	output logic                  done,
	output logic [PRM_DIST_W-1:0] quotient
);

	localparam int IW = $clog2(PRM_SUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [IW-1:0]        cnt_q;
	logic [PRM_CNT_W-1:0] rem_q;
	logic [PRM_SUM_W-1:0] dvd_q;
	logic [PRM_SUM_W-1:0] quo_q;
	logic [PRM_CNT_W:0]   trial;

	assign trial = {rem_q, dvd_q[PRM_SUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == IW'(PRM_SUM_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= dividend;
				quo_q  <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, divisor}) begin
					rem_q <= PRM_CNT_W'(trial - {1'b0, divisor});
					quo_q <= {quo_q[PRM_SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[PRM_CNT_W-1:0];
					quo_q <= {quo_q[PRM_SUM_W-2:0], 1'b0};
				end
				dvd_q <= {dvd_q[PRM_SUM_W-2:0], 1'b0};
				if (cnt_q == IW'(PRM_SUM_W - 1)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[PRM_DIST_W-1:0];

endmodule

// ===== design/polar_range_map_query_engine_top.sv =====
// Top level of the polar range map query engine: sequencer, map RAM and divider.
// Depends on prm_pkg, prm_ram and prm_div.
//
// One input channel carries point and query items, one output channel returns
// exactly one result item for each input item, in order. Both channels use
// valid and stall. After reset the block sweeps all MAP_DEGREES (360) map RAM
// entries to zero, one entry per cycle; in_stall stays high during that sweep.
// Items are handled one at a time. Farthest, nearest and object search read
// one map entry per cycle from the single RAM read port. Sector queries read
// 2*(width/2)+1 entries, and the average also runs the bit-serial divider.
// A finished result sits in an output register; the block takes the next
// item while it waits, and holds any later result until out_stall drops.
module polar_range_map_query_engine_top import prm_pkg::*; #(
	parameter int MAP_DEGREES = PRM_MAP_DEGREES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [3:0]            command,
	input  logic [14:0]           point_angle,
	input  logic [15:0]           point_distance,
	input  logic [7:0]            point_quality,
	input  logic signed [9:0]     range_start,
	input  logic signed [9:0]     range_end,
	input  logic [8:0]            range_step,
	input  logic signed [9:0]     sector_center,
	input  logic [8:0]            sector_width,
	input  logic [15:0]           limit_distance,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  found,
	output logic [8:0]            result_angle,
	output logic [15:0]           result_distance,
	output logic                  sector_is_clear,
	output logic                  scan_complete
);

	localparam int AW = $clog2(MAP_DEGREES);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_POINT, ST_SCAN, ST_DRAIN, ST_DIV, ST_DONE
	} state_t;

	state_t                state_q;
	prm_cmd_t              cmd_q;
	logic [AW-1:0]         clr_addr_q;
	logic [PRM_DEG_W-1:0]  last_deg_q;
	logic                  scan_flag_q;
	logic [14:0]           pa_q;
	logic [PRM_DIST_W-1:0] pd_q;
	logic [7:0]            pq_q;
	logic [PRM_DIST_W-1:0] limit_q;
	logic                  sector_q;
	logic [AW-1:0]         rd_addr_q;
	logic [PRM_DEG_W-1:0]  stop_q;
	logic [PRM_DEG_W-1:0]  end_q;
	logic                  wrap_q;
	logic [PRM_DEG_W-1:0]  step_q;
	logic [PRM_CNT_W-1:0]  left_q;
	logic                  valid_s1;
	logic [AW-1:0]         addr_s1;
	logic [PRM_DIST_W:0]   best_q;
	logic [PRM_DEG_W-1:0]  best_a_q;
	logic                  found_q;
	logic [PRM_DIST_W-1:0] mn_q;
	logic [PRM_DIST_W-1:0] mx_q;
	logic [PRM_SUM_W-1:0]  sum_q;
	logic [PRM_CNT_W-1:0]  cnt_q;
	logic                  clr_q;
	logic [PRM_DIST_W-1:0] avg_q;
	logic                  div_start_q;
	logic                  out_valid_q;
	logic                  found_out_q;
	logic [8:0]            angle_out_q;
	logic [15:0]           dist_out_q;
	logic                  clear_out_q;
	logic                  scan_out_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [PRM_DIST_W-1:0] ram_wdata;
	logic [PRM_DIST_W-1:0] ram_rdata;
	logic                  div_done;
	logic [PRM_DIST_W-1:0] div_quo;

	logic                  accept;
	logic [9:0]            idx_raw;
	logic [PRM_DEG_W-1:0]  idx;
	logic [PRM_DEG_W-1:0]  in_s;
	logic [PRM_DEG_W-1:0]  in_e;
	logic [PRM_DEG_W-1:0]  in_step;
	logic signed [11:0]    sec_lo;
	logic [9:0]            next_addr;
	logic                  take;
	logic [PRM_DIST_W-1:0] v;
	logic                  out_free;
	logic                  res_found;
	logic [8:0]            res_angle;
	logic [15:0]           res_dist;
	logic                  res_clear;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign idx_raw = 10'((16'(pa_q) + 16'd32) >> 6);
	assign idx     = (idx_raw >= 10'(MAP_DEGREES)) ? 9'(idx_raw - 10'(MAP_DEGREES))
	                                               : idx_raw[PRM_DEG_W-1:0];

	assign in_s    = prm_wrap(12'(range_start));
	assign in_e    = prm_wrap(12'(range_end));
	assign in_step = (command == CMD_OBJECT || range_step == '0) ? 9'd1 : range_step;
	assign sec_lo  = 12'(sector_center) - $signed({4'b0, sector_width[8:1]});

	assign next_addr = {1'b0, rd_addr_q} + {1'b0, step_q};
	assign v         = ram_rdata;

	always_comb begin
		case (cmd_q)
			CMD_FARTHEST: take = {1'b0, v} > best_q;
			CMD_NEAREST:  take = (v != '0) && ({1'b0, v} < best_q);
			default:      take = (v > 16'(PRM_OBJ_FLOOR)) && ({1'b0, v} < best_q);
		endcase
	end

	always_comb begin
		res_found = 1'b0;
		res_angle = '0;
		res_dist  = '0;
		res_clear = 1'b0;
		case (cmd_q)
			CMD_FARTHEST, CMD_NEAREST, CMD_OBJECT: begin
				res_found = found_q;
				res_angle = found_q ? best_a_q : '0;
			end
			CMD_SEC_MIN:   res_dist  = mn_q;
			CMD_SEC_MAX:   res_dist  = mx_q;
			CMD_SEC_AVG:   res_dist  = avg_q;
			CMD_SEC_CLEAR: res_clear = clr_q;
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == ST_POINT && cmd_q == CMD_POINT) begin
			ram_we    = (pq_q != '0) && (pd_q != '0);
			ram_waddr = AW'(idx);
			ram_wdata = pd_q;
		end
	end

	prm_ram #(
		.WIDTH(PRM_DIST_W),
		.DEPTH(MAP_DEGREES)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	prm_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start_q),
		.dividend(sum_q),
		.divisor (cnt_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cmd_q       <= CMD_POINT;
			clr_addr_q  <= '0;
			last_deg_q  <= 9'(PRM_NO_DEGREE);
			scan_flag_q <= 1'b0;
			pa_q        <= '0;
			pd_q        <= '0;
			pq_q        <= '0;
			limit_q     <= '0;
			sector_q    <= 1'b0;
			rd_addr_q   <= '0;
			stop_q      <= '0;
			end_q       <= '0;
			wrap_q      <= 1'b0;
			step_q      <= '0;
			left_q      <= '0;
			valid_s1    <= 1'b0;
			addr_s1     <= '0;
			best_q      <= '0;
			best_a_q    <= '0;
			found_q     <= 1'b0;
			mn_q        <= '0;
			mx_q        <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			clr_q       <= 1'b0;
			avg_q       <= '0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			found_out_q <= 1'b0;
			angle_out_q <= '0;
			dist_out_q  <= '0;
			clear_out_q <= 1'b0;
			scan_out_q  <= 1'b0;
		end else begin
			div_start_q <= (state_q == ST_DRAIN) && (cmd_q == CMD_SEC_AVG);
			valid_s1    <= (state_q == ST_SCAN);
			addr_s1     <= rd_addr_q;
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			if (valid_s1) begin
				if (sector_q) begin
					if (v > mx_q) begin
						mx_q <= v;
					end
					if (v != '0) begin
						if (cnt_q == '0 || v < mn_q) begin
							mn_q <= v;
						end
						sum_q <= sum_q + PRM_SUM_W'(v);
						cnt_q <= cnt_q + 1'b1;
						if (v < limit_q) begin
							clr_q <= 1'b0;
						end
					end
				end else if (take) begin
					best_q   <= {1'b0, v};
					best_a_q <= PRM_DEG_W'(addr_s1);
					found_q  <= 1'b1;
				end
			end

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MAP_DEGREES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= prm_cmd_t'(command);
						pa_q     <= point_angle;
						pd_q     <= point_distance;
						pq_q     <= point_quality;
						limit_q  <= limit_distance;
						step_q   <= in_step;
						end_q    <= in_e;
						found_q  <= 1'b0;
						best_a_q <= '0;
						mn_q     <= '0;
						mx_q     <= '0;
						sum_q    <= '0;
						cnt_q    <= '0;
						clr_q    <= 1'b1;
						avg_q    <= '0;
						case (command)
							CMD_POINT, CMD_CLR_SCAN: begin
								state_q <= ST_POINT;
							end
							CMD_FARTHEST, CMD_NEAREST, CMD_OBJECT: begin
								sector_q  <= 1'b0;
								rd_addr_q <= AW'(in_s);
								wrap_q    <= (in_s > in_e);
								stop_q    <= (in_s > in_e) ? 9'(MAP_DEGREES - 1) : in_e;
								if (command == CMD_FARTHEST) begin
									best_q <= '0;
								end else if (command == CMD_NEAREST) begin
									best_q <= '1;
								end else begin
									best_q <= {1'b0, limit_distance};
								end
								state_q <= ST_SCAN;
							end
							CMD_SEC_MIN, CMD_SEC_MAX, CMD_SEC_AVG, CMD_SEC_CLEAR: begin
								sector_q  <= 1'b1;
								rd_addr_q <= AW'(prm_wrap(sec_lo));
								left_q    <= {sector_width[8:1], 1'b1};
								state_q   <= ST_SCAN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_POINT: begin
					if (cmd_q == CMD_POINT) begin
						if (last_deg_q > 9'(PRM_SCAN_HI) && last_deg_q < 9'(MAP_DEGREES)
						    && idx < 9'(PRM_SCAN_LO)) begin
							scan_flag_q <= 1'b1;
						end
						last_deg_q <= idx;
					end else begin
						scan_flag_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (sector_q) begin
						rd_addr_q <= (rd_addr_q == AW'(MAP_DEGREES - 1)) ? '0
						                                                   : rd_addr_q + 1'b1;
						left_q    <= left_q - 1'b1;
						if (left_q == 9'd1) begin
							state_q <= ST_DRAIN;
						end
					end else if (next_addr > {1'b0, stop_q}) begin
						if (wrap_q) begin
							wrap_q    <= 1'b0;
							rd_addr_q <= '0;
							stop_q    <= end_q;
						end else begin
							state_q <= ST_DRAIN;
						end
					end else begin
						rd_addr_q <= AW'(next_addr);
					end
				end
				ST_DRAIN: begin
					if (cmd_q == CMD_SEC_AVG) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q   <= (cnt_q == '0) ? '0 : div_quo;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_out_q <= res_found;
						angle_out_q <= res_angle;
						dist_out_q  <= res_dist;
						clear_out_q <= res_clear;
						scan_out_q  <= scan_flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_out_q;
	assign result_angle    = angle_out_q;
	assign result_distance = dist_out_q;
	assign sector_is_clear = clear_out_q;
	assign scan_complete   = scan_out_q;

endmodule

// ===== tb/sv/prm_checker.sv =====
// Checker for the polar range map query engine: watches both channels,
// keeps its own copy of the range map and predicts every result item.
// Depends on prm_pkg.
module prm_checker import prm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [3:0]        command,
	input  logic [14:0]       point_angle,
	input  logic [15:0]       point_distance,
	input  logic [7:0]        point_quality,
	input  logic signed [9:0] range_start,
	input  logic signed [9:0] range_end,
	input  logic [8:0]        range_step,
	input  logic signed [9:0] sector_center,
	input  logic [8:0]        sector_width,
	input  logic [15:0]       limit_distance,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              found,
	input  logic [8:0]        result_angle,
	input  logic [15:0]       result_distance,
	input  logic              sector_is_clear,
	input  logic              scan_complete,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic        found;
		logic [8:0]  angle;
		logic [15:0] distance;
		logic        clear;
		logic        scan;
	} answer_t;

	logic [15:0] map_mirror [PRM_MAP_DEGREES];
	int          prev_degree;
	logic        scan_mirror;
	answer_t     answer_q[$];

	function automatic int wrap360(int d);
		int r;
		r = d % PRM_MAP_DEGREES;
		if (r < 0) r += PRM_MAP_DEGREES;
		return r;
	endfunction

	function automatic int search_range(int mode, int s, int e, int step, int limit);
		int best_d, best_a, a, stop, d;
		bit take;
		best_d = (mode == 0) ? 0 : (mode == 1 ? 32'h7fffffff : limit);
		best_a = -1;
		for (int p = 0; p < 2; p++) begin
			if (s <= e) begin
				if (p == 1) break;
				a = s; stop = e;
			end else if (p == 0) begin
				a = s; stop = PRM_MAP_DEGREES - 1;
			end else begin
				a = 0; stop = e;
			end
			for (; a <= stop; a += step) begin
				d = map_mirror[a];
				if (mode == 0) take = d > best_d;
				else if (mode == 1) take = d > 0 && d < best_d;
				else take = d > PRM_OBJ_FLOOR && d < best_d;
				if (take) begin
					best_d = d; best_a = a;
				end
			end
		end
		return best_a;
	endfunction

	function automatic answer_t predict_answer();
		answer_t r;
		int idx, s, e, step, hit, half, v, mn, mx, sum, cnt;
		r = '0;
		case (command)
			CMD_POINT: begin
				idx = ((int'(point_angle) + 32) >> 6) % PRM_MAP_DEGREES;
				if (prev_degree > PRM_SCAN_HI && prev_degree < PRM_MAP_DEGREES
						&& idx < PRM_SCAN_LO) scan_mirror = 1'b1;
				prev_degree = idx;
				if (point_quality != 0 && point_distance != 0) map_mirror[idx] = point_distance;
			end
			CMD_CLR_SCAN: scan_mirror = 1'b0;
			CMD_FARTHEST, CMD_NEAREST, CMD_OBJECT: begin
				s = wrap360(int'(range_start));
				e = wrap360(int'(range_end));
				step = (range_step == 0 || command == CMD_OBJECT) ? 1 : int'(range_step);
				hit = search_range(command == CMD_FARTHEST ? 0 : (command == CMD_NEAREST ? 1 : 2),
					s, e, step, int'(limit_distance));
				if (hit >= 0) begin
					r.found = 1'b1; r.angle = 9'(hit);
				end
			end
			CMD_SEC_MIN, CMD_SEC_MAX, CMD_SEC_AVG, CMD_SEC_CLEAR: begin
				half = int'(sector_width) / 2;
				mn = 0; mx = 0; sum = 0; cnt = 0;
				r.clear = 1'b1;
				for (int off = -half; off <= half; off++) begin
					v = map_mirror[wrap360(int'(sector_center) + off)];
					if (v > mx) mx = v;
					if (v > 0) begin
						if (cnt == 0 || v < mn) mn = v;
						sum += v; cnt++;
						if (v < int'(limit_distance)) r.clear = 1'b0;
					end
				end
				if (command == CMD_SEC_MIN) r.distance = 16'(mn);
				else if (command == CMD_SEC_MAX) r.distance = 16'(mx);
				else if (command == CMD_SEC_AVG) r.distance = 16'(cnt ? sum / cnt : 0);
				if (command != CMD_SEC_CLEAR) r.clear = 1'b0;
			end
			default: ;
		endcase
		r.scan = scan_mirror;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < PRM_MAP_DEGREES; i++) map_mirror[i] = '0;
		prev_degree = PRM_NO_DEGREE;
		scan_mirror = 1'b0;
	end

	assign pending = answer_q.size();

	always @(posedge clk) begin
		answer_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				report_mismatch("unexpected result item", 1, 0);
			end else begin
				w = answer_q.pop_front();
				if (found !== w.found) report_mismatch("found", found, w.found);
				if (result_angle !== w.angle) report_mismatch("result_angle", result_angle, w.angle);
				if (result_distance !== w.distance)
					report_mismatch("result_distance", result_distance, w.distance);
				if (sector_is_clear !== w.clear)
					report_mismatch("sector_is_clear", sector_is_clear, w.clear);
				if (scan_complete !== w.scan) report_mismatch("scan_complete", scan_complete, w.scan);
			end
		end
		if (arst_n && in_valid && !in_stall) answer_q.push_back(predict_answer());
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the polar range map query engine: clock, reset, stimulus
// and verdict. Depends on prm_pkg, prm_checker and the block itself.
module tb;
	import prm_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [3:0]        command = '0;
	logic [14:0]       point_angle = '0;
	logic [15:0]       point_distance = '0;
	logic [7:0]        point_quality = '0;
	logic signed [9:0] range_start = '0;
	logic signed [9:0] range_end = '0;
	logic [8:0]        range_step = '0;
	logic signed [9:0] sector_center = '0;
	logic [8:0]        sector_width = '0;
	logic [15:0]       limit_distance = '0;
	logic              out_valid;
	logic              out_stall = 1'b1;
	logic              found;
	logic [8:0]        result_angle;
	logic [15:0]       result_distance;
	logic              sector_is_clear;
	logic              scan_complete;
	int                fail_count;
	int                pending;
	int                cycle_count = 0;
	bit                calm = 1'b0;

	always #1 clk = ~clk;

	polar_range_map_query_engine_top u_dut (.*);

	prm_checker u_chk (.*);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 3000000) begin
			$display("polar_range_map_query_engine_top test failed");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 27);

	task automatic send_item(int cmd, int pa, int pd, int pq, int rs, int re, int st,
			int sc, int sw, int lim);
		while (!calm && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= 4'(cmd); point_angle <= 15'(pa); point_distance <= 16'(pd);
		point_quality <= 8'(pq);
		range_start <= 10'(rs); range_end <= 10'(re); range_step <= 9'(st);
		sector_center <= 10'(sc); sector_width <= 9'(sw); limit_distance <= 16'(lim);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random();
		int c, sw;
		c = $urandom_range(0, 99);
		sw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40);
		if (c < 45) c = CMD_POINT;
		else if (c < 48) c = CMD_CLR_SCAN;
		else if (c < 95) c = $urandom_range(CMD_FARTHEST, CMD_OBJECT);
		else c = $urandom_range(0, 15);
		send_item(c, $urandom_range(0, 32767),
			($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535),
			($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 255),
			$urandom_range(0, 1023), $urandom_range(0, 1023),
			($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 12),
			$urandom_range(0, 1023), sw,
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_item(CMD_POINT, 23039, 100, 1, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 358 * 64, 65535, 255, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 32, 50, 7, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 5 * 64, 0, 9, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 6 * 64, 9, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 32767, 200, 3, 0, 0, 0, 0, 0, 0);
		send_item(CMD_POINT, 90 * 64 + 31, 81, 3, 0, 0, 0, 0, 0, 0);
		send_item(CMD_FARTHEST, 0, 0, 0, -360, 359, 0, 0, 0, 0);
		send_item(CMD_NEAREST, 0, 0, 0, 350, 20, 3, 0, 0, 0);
		send_item(CMD_NEAREST, 0, 0, 0, 100, 100, 359, 0, 0, 0);
		send_item(CMD_OBJECT, 0, 0, 0, -10, 200, 5, 0, 0, 65535);
		send_item(CMD_OBJECT, 0, 0, 0, 0, 359, 0, 0, 0, 81);
		send_item(CMD_SEC_MIN, 0, 0, 0, 0, 0, 0, -360, 40, 0);
		send_item(CMD_SEC_MAX, 0, 0, 0, 0, 0, 0, 359, 511, 0);
		send_item(CMD_SEC_AVG, 0, 0, 0, 0, 0, 0, 0, 511, 0);
		send_item(CMD_SEC_AVG, 0, 0, 0, 0, 0, 0, 200, 1, 0);
		send_item(CMD_SEC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 30, 60);
		send_item(CMD_SEC_CLEAR, 0, 0, 0, 0, 0, 0, 200, 0, 65535);
		send_item(CMD_CLR_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(15, 32767, 65535, 255, -1, -1, 511, -1, 511, 65535);
		send_item(9, 0, 0, 0, -512, -512, 0, -512, 0, 0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		for (int i = 0; i < 1050; i++) begin
			calm = (i >= 400 && i < 500);
			send_random();
			if (i == 700) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0) $display("polar_range_map_query_engine_top test passed");
		else $display("polar_range_map_query_engine_top test failed");
		$finish;
	end

endmodule
